// ----- sv/round_robin_slice_scheduler_core_defines.svh -----
// assertion helpers used by rrss_dp
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define RRSS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RRSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/rrss_pkg.sv -----
package rrss_pkg;

   localparam int MODE_W      = 2;
   localparam int FIELD_W     = 16;
   localparam int INDEX_W     = 6;
   localparam int WAIT_W      = 24;
   localparam int CUR_W       = 22;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;

   localparam logic [CUR_W-1:0]   CUR_MAX       = {CUR_W{1'b1}};
   localparam logic [FIELD_W-1:0] QUANTUM_RESET = 16'd2;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GRANT,
      ST_RESULT,
      ST_DONE
   } rrss_state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic step_start;
      logic scan_issue;
      logic grant;
      logic out_job;
      logic out_done;
   } rrss_cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_end;
      logic out_free;
   } rrss_status_type;

endpackage

// ----- sv/rrss_ctrl.sv -----
module rrss_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic [rrss_pkg::MODE_W-1:0] req_mode,
   output logic                        req_tready,
   input  rrss_pkg::rrss_status_type   status,
   output rrss_pkg::rrss_cmd_type      cmd
);
   import rrss_pkg::*;

   rrss_state_type state_ff;
   rrss_state_type state_in;
   logic           accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_STEP)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (status.scan_hit) begin
               state_in = ST_GRANT;
            end else if (status.scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_GRANT: begin
            state_in = ST_RESULT;
         end
         ST_RESULT, ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            unique case (req_mode)
               MODE_CLEAR: cmd.clear      = accept;
               MODE_LOAD:  cmd.load       = accept;
               MODE_STEP:  cmd.step_start = accept;
               default:    cmd            = '0;
            endcase
         end
         ST_SCAN: begin
            cmd.scan_issue = !status.scan_hit;
         end
         ST_GRANT: begin
            cmd.grant = 1'b1;
         end
         ST_RESULT: begin
            cmd.out_job = status.out_free;
         end
         ST_DONE: begin
            cmd.out_done = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/rrss_dp.sv -----
`include "round_robin_slice_scheduler_core_defines.svh"

module rrss_dp #(
   parameter int MAX_JOBS   = 64,
   parameter int TIME_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rrss_pkg::rrss_cmd_type           cmd,
   output rrss_pkg::rrss_status_type        status,
   input  logic [rrss_pkg::FIELD_W-1:0]     arrival_time,
   input  logic [rrss_pkg::FIELD_W-1:0]     duration,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rrss_pkg::FIELD_W-1:0]     csr_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rrss_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                       rsp_tuser
);
   import rrss_pkg::*;

   localparam int TW = (TIME_WIDTH < FIELD_W) ? TIME_WIDTH : FIELD_W;
   localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW = $clog2(MAX_JOBS + 1);

   logic [TW-1:0]     rem_mem_ff [MAX_JOBS];
   logic [2*TW-1:0]   aux_mem_ff [MAX_JOBS];

   logic [FIELD_W-1:0] quantum_ff, quantum_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      scan_pos_ff, scan_pos_in;
   logic [CUR_W-1:0]   cur_ff, cur_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      issued_ff, issued_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pend_slot_ff, pend_slot_in;
   logic [TW-1:0]      rem_rd_ff;
   logic [TW-1:0]      arr_rd_ff;
   logic [TW-1:0]      dur_rd_ff;
   logic [TW-1:0]      grant_ff, grant_in;
   logic               fin_ff, fin_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   logic [TW-1:0]      q_raw, q_eff, grant_val, rem_new;
   logic [CUR_W:0]     cur_sum;
   logic [CUR_W-1:0]   cur_sat;
   logic [CW:0]        count_ext, slot_inc, pend_inc;
   logic [IW-1:0]      slot_next, pend_next, start_slot;
   logic               issue_ok, room, rem_we;
   logic [IW-1:0]      rem_waddr;
   logic [TW-1:0]      rem_wdata;
   logic [WAIT_W-1:0]  wait_val;

   assign csr_ready = 1'b1;

   assign q_raw     = quantum_ff[TW-1:0];
   assign q_eff     = (q_raw == '0) ? TW'(1) : q_raw;
   assign grant_val = (rem_rd_ff < q_eff) ? rem_rd_ff : q_eff;
   assign rem_new   = rem_rd_ff - grant_val;
   assign cur_sum   = {1'b0, cur_ff} + (CUR_W + 1)'(grant_val);
   assign cur_sat   = (cur_sum > (CUR_W + 1)'(CUR_MAX)) ? CUR_MAX : cur_sum[CUR_W-1:0];

   assign count_ext  = (CW + 1)'(count_ff);
   assign slot_inc   = (CW + 1)'(slot_ff) + (CW + 1)'(1);
   assign slot_next  = (slot_inc >= count_ext) ? '0 : slot_inc[IW-1:0];
   assign pend_inc   = (CW + 1)'(pend_slot_ff) + (CW + 1)'(1);
   assign pend_next  = (pend_inc >= count_ext) ? '0 : pend_inc[IW-1:0];
   assign start_slot = ((CW + 1)'(scan_pos_ff) < count_ext) ? scan_pos_ff : '0;
   assign issue_ok   = issued_ff < count_ff;
   assign room       = count_ff < CW'(MAX_JOBS);

   assign rem_we    = (cmd.load && room) || cmd.grant;
   assign rem_waddr = cmd.grant ? pend_slot_ff : count_ff[IW-1:0];
   assign rem_wdata = cmd.grant ? rem_new : duration[TW-1:0];

   assign wait_val = fin_ff ? (WAIT_W'(cur_ff) - WAIT_W'(arr_rd_ff) - WAIT_W'(dur_rd_ff))
                            : '0;

   assign status.scan_hit = pend_ff && (rem_rd_ff != '0);
   assign status.scan_end = !pend_ff && !issue_ok;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      quantum_in   = quantum_ff;
      count_in     = count_ff;
      scan_pos_in  = scan_pos_ff;
      cur_in       = cur_ff;
      slot_in      = slot_ff;
      issued_in    = issued_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      grant_in     = grant_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid) begin
         quantum_in = csr_data;
      end
      if (cmd.clear) begin
         count_in    = '0;
         scan_pos_in = '0;
         cur_in      = '0;
      end
      if (cmd.load && room) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.step_start) begin
         slot_in   = start_slot;
         issued_in = '0;
         pend_in   = 1'b0;
      end
      if (cmd.scan_issue) begin
         pend_in = issue_ok;
         if (issue_ok) begin
            slot_in      = slot_next;
            issued_in    = issued_ff + CW'(1);
            pend_slot_in = slot_ff;
         end
      end
      if (cmd.grant) begin
         cur_in      = cur_sat;
         scan_pos_in = pend_next;
         grant_in    = grant_val;
         fin_in      = (rem_new == '0);
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_job) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = 1'b0;
         rsp_data_in  = {1'b0, wait_val, fin_ff, FIELD_W'(grant_ff), INDEX_W'(pend_slot_ff)};
      end
      if (cmd.out_done) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = 1'b1;
         rsp_data_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= QUANTUM_RESET;
         count_ff     <= '0;
         scan_pos_ff  <= '0;
         cur_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quantum_ff   <= quantum_in;
         count_ff     <= count_in;
         scan_pos_ff  <= scan_pos_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      issued_ff    <= issued_in;
      pend_slot_ff <= pend_slot_in;
      grant_ff     <= grant_in;
      fin_ff       <= fin_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // remaining time: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem_ff[rem_waddr] <= rem_wdata;
      end
      if (cmd.scan_issue && issue_ok) begin
         rem_rd_ff <= rem_mem_ff[slot_ff];
      end
   end

   // arrival and duration
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         aux_mem_ff[count_ff[IW-1:0]] <= {duration[TW-1:0], arrival_time[TW-1:0]};
      end
      if (cmd.scan_issue && issue_ok) begin
         {dur_rd_ff, arr_rd_ff} <= aux_mem_ff[slot_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `RRSS_ASSERT_IMPL(a_grant_has_job, clock, reset, cmd.grant, pend_ff && (rem_rd_ff != '0), "grant without a job holding time")
   `RRSS_ASSERT_IMPL(a_out_slot_free, clock, reset, cmd.out_job || cmd.out_done, status.out_free, "result loaded over a waiting word")
   `RRSS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_JOBS), "job count beyond table size")
   `RRSS_ASSERT_NEXT(a_time_forward, clock, reset, cmd.grant, cur_ff >= $past(cur_ff), "current time went backward")

endmodule

// ----- sv/round_robin_slice_scheduler_core.sv -----
// Round-robin slice scheduler with a fixed quantum over a table of up to MAX_JOBS jobs.
// The request word carries the mode in req_tuser (clear, load, step); clear and load give
// no response, and a load into a full table is dropped. A step walks the remaining-time
// memory one slot per cycle from the slot after the last grant, examining at most the job
// count of slots; the response register may then wait for rsp_tready. The response is
// either a grant (slot, slice length, finished flag, wait time) or, with rsp_tuser set,
// an all-done word with every other field zero. The user must write the quantum through
// the csr port only while the block is idle; the block itself does not enforce this. A
// quantum of zero acts as one.
module round_robin_slice_scheduler_core #(
   parameter int MAX_JOBS   = 64,
   parameter int TIME_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rrss_pkg::REQ_TDATA_W-1:0] req_tdata,  // arrival_time, duration
   input  logic [rrss_pkg::MODE_W-1:0]      req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rrss_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // job_index, slice_length, finished, wait_time, pad
   output logic [0:0]                       rsp_tuser,  // all_done
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rrss_pkg::FIELD_W-1:0]     csr_data    // quantum
);
   import rrss_pkg::*;

   rrss_cmd_type    cmd;
   rrss_status_type status;

   rrss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrss_dp #(
      .MAX_JOBS   (MAX_JOBS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .arrival_time (req_tdata[FIELD_W-1:0]),
      .duration     (req_tdata[2*FIELD_W-1:FIELD_W]),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ----- tb/rrss_grant_checker.sv -----
module rrss_grant_checker #(
   parameter int MAX_JOBS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [rrss_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [rrss_pkg::MODE_W-1:0]      req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rrss_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [0:0]                       rsp_tuser,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [rrss_pkg::FIELD_W-1:0]     csr_data,
   output int                               fail_count,
   output int                               pending
);
   import rrss_pkg::*;

   localparam int SLICE_LSB = INDEX_W;
   localparam int DONE_BIT  = INDEX_W + FIELD_W;
   localparam int WAIT_LSB  = DONE_BIT + 1;

   typedef struct packed {
      logic [INDEX_W-1:0] job_index;
      logic [FIELD_W-1:0] slice_length;
      logic               finished;
      logic [WAIT_W-1:0]  wait_time;
      logic               all_done;
   } grant_word_type;

   grant_word_type     expected_grants[$];
   grant_word_type     got;
   grant_word_type     want;
   logic [FIELD_W-1:0] quantum;
   logic [FIELD_W-1:0] time_left [MAX_JOBS];
   logic [FIELD_W-1:0] job_arrival [MAX_JOBS];
   logic [FIELD_W-1:0] job_length [MAX_JOBS];
   int unsigned        job_count;
   int unsigned        next_slot;
   logic [CUR_W-1:0]   now_time;
   int                 errors = 0;
   int                 shown = 0;

   // grant the next job with time left, circularly from the slot after the last grant
   function automatic grant_word_type run_slice();
      grant_word_type     g;
      int unsigned        first;
      int unsigned        slot;
      logic [FIELD_W-1:0] q;
      logic [FIELD_W-1:0] give;
      logic [CUR_W:0]     t;
      int                 w;
      g = '0;
      first = (next_slot < job_count) ? next_slot : 0;
      for (int k = 0; k < job_count; k++) begin
         slot = first + k;
         if (slot >= job_count) slot -= job_count;
         if (time_left[slot] != '0) begin
            q = (quantum == '0) ? FIELD_W'(1) : quantum;
            give = (time_left[slot] < q) ? time_left[slot] : q;
            time_left[slot] -= give;
            t = now_time + give;
            now_time = (t > CUR_MAX) ? CUR_MAX : t[CUR_W-1:0];
            next_slot = (slot + 1 < job_count) ? slot + 1 : 0;
            g.job_index = slot[INDEX_W-1:0];
            g.slice_length = give;
            if (time_left[slot] == '0) begin
               w = int'(now_time) - int'(job_arrival[slot]) - int'(job_length[slot]);
               g.finished = 1'b1;
               g.wait_time = w[WAIT_W-1:0];
            end
            return g;
         end
      end
      g.all_done = 1'b1;
      return g;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         quantum = QUANTUM_RESET;
         job_count = 0;
         next_slot = 0;
         now_time = '0;
         expected_grants.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.job_index = rsp_tdata[INDEX_W-1:0];
            got.slice_length = rsp_tdata[SLICE_LSB +: FIELD_W];
            got.finished = rsp_tdata[DONE_BIT];
            got.wait_time = rsp_tdata[WAIT_LSB +: WAIT_W];
            got.all_done = rsp_tuser[0];
            if (expected_grants.size() == 0) begin
               errors++;
               if (shown < 10) begin
                  shown++;
                  $display("unexpected response word: idx %0d len %0d fin %0b wait %0d done %0b",
                           got.job_index, got.slice_length, got.finished,
                           $signed(got.wait_time), got.all_done);
               end
            end else begin
               want = expected_grants.pop_front();
               if (got.job_index !== want.job_index || got.slice_length !== want.slice_length
                   || got.finished !== want.finished || got.wait_time !== want.wait_time
                   || got.all_done !== want.all_done) begin
                  errors++;
                  if (shown < 10) begin
                     shown++;
                     $display("mismatch: expected idx %0d len %0d fin %0b wait %0d done %0b",
                              want.job_index, want.slice_length, want.finished,
                              $signed(want.wait_time), want.all_done);
                     $display("          actual   idx %0d len %0d fin %0b wait %0d done %0b",
                              got.job_index, got.slice_length, got.finished,
                              $signed(got.wait_time), got.all_done);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) quantum = csr_data;
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               MODE_CLEAR: begin
                  job_count = 0;
                  next_slot = 0;
                  now_time = '0;
               end
               MODE_LOAD: begin
                  if (job_count < MAX_JOBS) begin
                     job_arrival[job_count] = req_tdata[FIELD_W-1:0];
                     job_length[job_count] = req_tdata[FIELD_W +: FIELD_W];
                     time_left[job_count] = req_tdata[FIELD_W +: FIELD_W];
                     job_count++;
                  end
               end
               MODE_STEP: expected_grants.push_back(run_slice());
               default: ;
            endcase
         end
      end
      pending <= expected_grants.size();
      fail_count <= errors;
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import rrss_pkg::*;

   localparam int MAX_JOBS    = 64;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 80;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // arrival_time, duration
   logic [MODE_W-1:0]      req_tuser = '0;   // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // job_index, slice_length, finished, wait_time, pad
   logic [0:0]             rsp_tuser;        // all_done
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [FIELD_W-1:0]     csr_data = '0;   // quantum
   int                     fail_count;
   int                     pending;

   bit                     steady = 1'b0;
   int                     word_count = 0;
   logic [FIELD_W-1:0]     q_now = QUANTUM_RESET;
   int                     eff_q = 2;

   round_robin_slice_scheduler_core #(.MAX_JOBS(MAX_JOBS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   rrss_grant_checker #(.MAX_JOBS(MAX_JOBS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 22);
   end

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] arrival,
                            input logic [FIELD_W-1:0] duration);
      while (!steady && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {duration, arrival};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode != MODE_UNUSED) word_count++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [FIELD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      q_now = value;
      eff_q = (value == '0) ? 1 : int'(value);
   endtask

   function automatic logic [FIELD_W-1:0] pick_duration();
      int top;
      if (q_now == '1) return ($urandom_range(1) != 0) ? '1 : FIELD_W'($urandom);
      if ($urandom_range(19) == 0) return '0;
      top = (eff_q > 16383) ? 65535 : 4 * eff_q;
      return FIELD_W'($urandom_range(1, top));
   endfunction

   function automatic logic [FIELD_W-1:0] pick_arrival();
      return ($urandom_range(1) != 0) ? FIELD_W'($urandom) : FIELD_W'($urandom_range(0, 63));
   endfunction

   initial begin
      int target;
      int mark;
      int jobs;
      int slices;
      int n;
      int r;
      logic [FIELD_W-1:0] dur;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, unused mode, zero duration, negative wait
      send_word(MODE_STEP, '0, '0);
      send_word(MODE_UNUSED, '1, '1);
      send_word(MODE_LOAD, '0, '0);
      send_word(MODE_LOAD, '1, 16'd5);
      send_word(MODE_LOAD, '0, 16'd1);
      send_word(MODE_LOAD, 16'd1234, 16'd3);
      repeat (8) send_word(MODE_STEP, '0, '0);
      settle();
      // zero quantum acts as one
      write_quantum('0);
      send_word(MODE_CLEAR, '0, '0);
      send_word(MODE_LOAD, 16'd7, 16'd2);
      repeat (3) send_word(MODE_STEP, '0, '0);
      settle();
      write_quantum('1);
      send_word(MODE_CLEAR, '1, '1);
      send_word(MODE_LOAD, '0, '1);
      send_word(MODE_LOAD, '1, '1);
      repeat (3) send_word(MODE_STEP, '0, '0);

      target = word_count + 1250;
      mark = word_count + 400;
      while (word_count < target) begin
         steady = (word_count >= mark && word_count < mark + 250);
         if ($urandom_range(4) == 0) begin
            settle();
            case ($urandom_range(7))
               0: write_quantum('0);
               1: write_quantum(16'd1);
               2: write_quantum('1);
               3: write_quantum(QUANTUM_RESET);
               4, 5: write_quantum(FIELD_W'($urandom_range(1, 64)));
               6: write_quantum(FIELD_W'($urandom_range(65, 65534)));
               default: write_quantum(FIELD_W'($urandom_range(3, 16)));
            endcase
         end
         r = $urandom_range(99);
         if (r < 70) begin
            send_word(MODE_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom));
            jobs = ($urandom_range(9) == 0) ? $urandom_range(56, 70) : $urandom_range(1, 10);
            slices = 0;
            for (int j = 0; j < jobs; j++) begin
               dur = pick_duration();
               send_word(MODE_LOAD, pick_arrival(), dur);
               if (j < MAX_JOBS) slices += (int'(dur) + eff_q - 1) / eff_q;
            end
            repeat (slices + $urandom_range(0, 2)) send_word(MODE_STEP, '0, '0);
         end else if (r < 88) begin
            n = $urandom_range(3, 20);
            repeat (n) begin
               r = $urandom_range(99);
               if (r < 45) send_word(MODE_LOAD, pick_arrival(), pick_duration());
               else if (r < 90) send_word(MODE_STEP, FIELD_W'($urandom), FIELD_W'($urandom));
               else if (r < 95) send_word(MODE_CLEAR, '0, '0);
               else send_word(MODE_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom));
            end
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) begin
               send_word(MODE_W'($urandom_range(3)), FIELD_W'($urandom), FIELD_W'($urandom));
            end
         end
      end
      steady = 1'b0;

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- round_robin_slice_scheduler_core.f -----
+incdir+sv
sv/rrss_pkg.sv
sv/rrss_ctrl.sv
sv/rrss_dp.sv
sv/round_robin_slice_scheduler_core.sv
tb/rrss_grant_checker.sv
tb/tb_top.sv
